// ===== sv/elevator_direction_dispatch_macros.svh =====
// ----------------------------------------------------------------------------
// Elevator direction dispatch assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_DIRECTION_DISPATCH_MACROS_SVH
`define ELEVATOR_DIRECTION_DISPATCH_MACROS_SVH

// Check a property on every rising edge outside reset.
`define EDD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dispatch assertion failed");

// Check an implication on every rising edge outside reset.
`define EDD_ASSERT_IMPL(label, cond, prop) \
    `EDD_ASSERT(label, (cond) |-> (prop))

`endif

// ===== sv/edd_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator direction dispatch package
// Shared types, sizes and call-scan helpers.
// ----------------------------------------------------------------------------
package edd_pkg;

    localparam int FLOORS      = 16;
    localparam int MASK_BITS   = 16;
    localparam int FLOOR_W     = 4;
    localparam int FLOOR_LIMIT = (FLOORS < MASK_BITS) ? FLOORS : MASK_BITS;

    typedef logic [MASK_BITS-1:0] t_mask;
    typedef logic [FLOOR_W-1:0]   t_floor;

    // Floors that exist; mask bits above are dropped.
    localparam t_mask FLOOR_MASK = (FLOOR_LIMIT >= MASK_BITS) ? '1 :
                                   t_mask'((64'(1) << FLOOR_LIMIT) - 64'(1));

    typedef enum logic [1:0] {
        HEAD_IDLE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    typedef struct packed {
        t_mask  hall_up_mask;
        t_mask  hall_down_mask;
        t_mask  cabin_mask;
        t_floor car_floor;
        logic   cabin_full;
    } t_req;

    typedef struct packed {
        logic   hit;
        t_floor idx;
    } t_find;

    // Lowest set bit: isolate it, then OR-encode the one-hot position.
    function automatic t_find find_lowest(t_mask m);
        t_mask one_hot;
        t_find res;
        one_hot = m & (~m + t_mask'(1));
        res.hit = |m;
        res.idx = '0;
        for (int i = 0; i < MASK_BITS; i++) begin
            if (one_hot[i]) begin
                res.idx = res.idx | t_floor'(i);
            end
        end
        return res;
    endfunction

    // Highest set bit: reverse the mask and reuse the lowest-bit search.
    function automatic t_find find_highest(t_mask m);
        t_mask rev;
        t_find low;
        t_find res;
        for (int i = 0; i < MASK_BITS; i++) begin
            rev[i] = m[MASK_BITS-1-i];
        end
        low     = find_lowest(rev);
        res.hit = low.hit;
        res.idx = t_floor'(MASK_BITS - 1) - low.idx;
        return res;
    endfunction

endpackage

// ===== sv/edd_req_if.sv =====
// ----------------------------------------------------------------------------
// Dispatch request channel
// Valid/ready channel carrying call masks, current floor and the full flag.
// ----------------------------------------------------------------------------
interface edd_req_if;
    logic                   valid;
    logic                   ready;
    logic [15:0]            hall_up_mask;
    logic [15:0]            hall_down_mask;
    logic [15:0]            cabin_mask;
    logic [3:0]             car_floor;
    logic                   cabin_full;

    modport source (
        output valid, hall_up_mask, hall_down_mask, cabin_mask, car_floor, cabin_full,
        input  ready
    );
    modport sink (
        input  valid, hall_up_mask, hall_down_mask, cabin_mask, car_floor, cabin_full,
        output ready
    );
endinterface

// ===== sv/edd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Dispatch result channel
// Valid/ready channel carrying the target floor and the new heading.
// ----------------------------------------------------------------------------
interface edd_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] next_floor;
    logic [1:0] heading;

    modport source (
        output valid, next_floor, heading,
        input  ready
    );
    modport sink (
        input  valid, next_floor, heading,
        output ready
    );
endinterface

// ===== sv/elevator_direction_dispatch.sv =====
// Pipeline: a request transaction goes into the input register, then into the
//          result register that also holds the heading and target state;
//          a stalled result receiver can hold it in the input register.
// Throughput: one transaction per cycle while the result receiver is ready; the
//             four call scans and the heading update fit between the two registers.
// Reset (i_rst_n low, synchronous): both stages empty, heading idle, target 0.
// ----------------------------------------------------------------------------
// Elevator direction dispatch
// LOOK-style dispatch: nearest up and down requests, then heading update.
// ----------------------------------------------------------------------------
`include "elevator_direction_dispatch_macros.svh"

module elevator_direction_dispatch (
    input  logic      i_clk,
    input  logic      i_rst_n,
    edd_req_if.sink   i_req,
    edd_rsp_if.source o_rsp
);

    // Input stage
    logic           r_in_valid;
    edd_pkg::t_req  r_in;

    // Result stage; the kept heading and target double as the result payload,
    // since they change only when a result is loaded.
    logic             r_out_valid;
    edd_pkg::t_heading r_heading;
    edd_pkg::t_floor   r_target;

    edd_pkg::t_heading n_heading;
    edd_pkg::t_floor   n_target;

    logic            w_adv;
    edd_pkg::t_mask  w_cur_bit;
    edd_pkg::t_mask  w_below;
    edd_pkg::t_mask  w_ge;
    edd_pkg::t_mask  w_gt;
    edd_pkg::t_mask  w_le;
    edd_pkg::t_mask  w_hall_keep;
    edd_pkg::t_find  w_up_near;
    edd_pkg::t_find  w_up_far;
    edd_pkg::t_find  w_dn_near;
    edd_pkg::t_find  w_dn_far;
    edd_pkg::t_find  w_up;
    edd_pkg::t_find  w_dn;

    // Advance the input stage whenever the result slot is free or draining.
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.next_floor = r_target;
    assign o_rsp.heading    = 2'(r_heading);

    // Floor-relative masks around the current floor.
    assign w_cur_bit   = edd_pkg::t_mask'(1) << r_in.car_floor;
    assign w_below     = w_cur_bit - edd_pkg::t_mask'(1);
    assign w_ge        = ~w_below;
    assign w_gt        = w_ge & ~w_cur_bit;
    assign w_le        = w_below | w_cur_bit;
    // A full cabin ignores hall calls at its own floor; cabin calls still count.
    assign w_hall_keep = r_in.cabin_full ? ~w_cur_bit : '1;

    // Up request: nearest cabin or hall-up call at or above, else nearest
    // hall-down call strictly above.
    assign w_up_near = edd_pkg::find_lowest((r_in.cabin_mask |
                           (r_in.hall_up_mask & w_hall_keep)) & w_ge & edd_pkg::FLOOR_MASK);
    assign w_up_far  = edd_pkg::find_lowest(r_in.hall_down_mask & w_gt & edd_pkg::FLOOR_MASK);
    assign w_up      = w_up_near.hit ? w_up_near : w_up_far;

    // Down request: mirror image, scanning downward.
    assign w_dn_near = edd_pkg::find_highest((r_in.cabin_mask |
                           (r_in.hall_down_mask & w_hall_keep)) & w_le & edd_pkg::FLOOR_MASK);
    assign w_dn_far  = edd_pkg::find_highest(r_in.hall_up_mask & w_below & edd_pkg::FLOOR_MASK);
    assign w_dn      = w_dn_near.hit ? w_dn_near : w_dn_far;

    // Heading update: continue, else reverse, else idle; from idle, up wins over down.
    always_comb begin
        n_heading = r_heading;
        n_target  = r_target;
        unique case (r_heading)
            edd_pkg::HEAD_UP: begin
                priority if (w_up.hit) begin
                    n_target = w_up.idx;
                end else if (w_dn.hit) begin
                    n_heading = edd_pkg::HEAD_DOWN;
                    n_target  = w_dn.idx;
                end else begin
                    // Hold the old target when a moving cabin runs out of work.
                    n_heading = edd_pkg::HEAD_IDLE;
                end
            end
            edd_pkg::HEAD_DOWN: begin
                priority if (w_dn.hit) begin
                    n_target = w_dn.idx;
                end else if (w_up.hit) begin
                    n_heading = edd_pkg::HEAD_UP;
                    n_target  = w_up.idx;
                end else begin
                    n_heading = edd_pkg::HEAD_IDLE;
                end
            end
            default: begin
                // Idle, and the unused code, which acts as idle.
                priority if (w_up.hit) begin
                    n_heading = edd_pkg::HEAD_UP;
                    n_target  = w_up.idx;
                end else if (w_dn.hit) begin
                    n_heading = edd_pkg::HEAD_DOWN;
                    n_target  = w_dn.idx;
                end else begin
                    // Idle with nothing to do: park at the current floor.
                    n_heading = edd_pkg::HEAD_IDLE;
                    n_target  = r_in.car_floor;
                end
            end
        endcase
    end

    // Control and kept state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_heading   <= edd_pkg::HEAD_IDLE;
            r_target    <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_heading   <= n_heading;
                r_target    <= n_target;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request payload on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.hall_up_mask   <= i_req.hall_up_mask;
            r_in.hall_down_mask <= i_req.hall_down_mask;
            r_in.cabin_mask     <= i_req.cabin_mask;
            r_in.car_floor      <= i_req.car_floor;
            r_in.cabin_full     <= i_req.cabin_full;
        end
    end

    // Every accepted transaction lands in the input stage.
    `EDD_ASSERT_IMPL(a_accept_fills, i_req.valid && i_req.ready, ##1 r_in_valid)
    // Every advance produces a result in the next cycle.
    `EDD_ASSERT_IMPL(a_adv_loads, w_adv, ##1 r_out_valid)
    // Heading up always targets a floor at or above the cabin.
    `EDD_ASSERT_IMPL(a_up_above, w_adv && n_heading == edd_pkg::HEAD_UP,
                     n_target >= r_in.car_floor)
    // Heading down always targets a floor at or below the cabin.
    `EDD_ASSERT_IMPL(a_down_below, w_adv && n_heading == edd_pkg::HEAD_DOWN,
                     n_target <= r_in.car_floor)

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Elevator direction dispatch testbench
// Drives call masks, floor and full flag through the request channel and
// predicts each target floor and heading from its own copy of the heading
// and target state. Every result transaction is checked in order. Directed
// corner calls come first. Random traffic follows in four pacing phases:
// steady, sender gaps, receiver stalls, and both at once.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pacing of the two channels during a phase of random traffic.
    typedef enum logic [1:0] {
        PACE_STEADY = 2'd0,
        PACE_SRC_GAPS = 2'd1,
        PACE_SINK_STALLS = 2'd2,
        PACE_BOTH_GAPS = 2'd3
    } t_pace;

    typedef struct packed {
        edd_pkg::t_floor   dest_floor;
        edd_pkg::t_heading heading;
    } t_move;

    localparam int PHASE_CALLS = 275;

    logic i_clk = 1'b0;
    logic i_rst_n;

    edd_req_if req_ch ();
    edd_rsp_if rsp_ch ();

    elevator_direction_dispatch i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    edd_pkg::t_req     pending_calls[$];
    t_move             expected_moves[$];
    edd_pkg::t_heading heading_now;
    edd_pkg::t_floor   target_now;
    t_pace             pace;
    logic              req_taken;
    int                mismatches;
    int                walk_floor;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Nearest request at or above the cabin; fall back to a down call
    // strictly above. A full cabin ignores the hall call at its own floor.
    function automatic int nearest_up(edd_pkg::t_req r);
        int cur;
        cur = int'(r.car_floor);
        for (int f = cur; f < edd_pkg::FLOOR_LIMIT; f++) begin
            if (r.cabin_mask[f] || (r.hall_up_mask[f] && (f > cur || !r.cabin_full))) begin
                return f;
            end
        end
        for (int f = cur + 1; f < edd_pkg::FLOOR_LIMIT; f++) begin
            if (r.hall_down_mask[f]) begin
                return f;
            end
        end
        return -1;
    endfunction

    // Mirror of the upward scan.
    function automatic int nearest_down(edd_pkg::t_req r);
        int cur;
        cur = int'(r.car_floor);
        for (int f = cur; f >= 0; f--) begin
            if (f < edd_pkg::FLOOR_LIMIT) begin
                if (r.cabin_mask[f] ||
                    (r.hall_down_mask[f] && (f < cur || !r.cabin_full))) begin
                    return f;
                end
            end
        end
        for (int f = cur - 1; f >= 0; f--) begin
            if (f < edd_pkg::FLOOR_LIMIT && r.hall_up_mask[f]) begin
                return f;
            end
        end
        return -1;
    endfunction

    // Advance the kept heading and target by one decision: continue, else
    // reverse, else go idle; from idle, up wins over down.
    function automatic t_move dispatch_step(edd_pkg::t_req r);
        int    up_at;
        int    dn_at;
        t_move m;
        up_at = nearest_up(r);
        dn_at = nearest_down(r);
        case (heading_now)
            edd_pkg::HEAD_UP: begin
                if (up_at >= 0) begin
                    target_now = edd_pkg::t_floor'(up_at);
                end else if (dn_at >= 0) begin
                    heading_now = edd_pkg::HEAD_DOWN;
                    target_now  = edd_pkg::t_floor'(dn_at);
                end else begin
                    heading_now = edd_pkg::HEAD_IDLE;
                end
            end
            edd_pkg::HEAD_DOWN: begin
                if (dn_at >= 0) begin
                    target_now = edd_pkg::t_floor'(dn_at);
                end else if (up_at >= 0) begin
                    heading_now = edd_pkg::HEAD_UP;
                    target_now  = edd_pkg::t_floor'(up_at);
                end else begin
                    heading_now = edd_pkg::HEAD_IDLE;
                end
            end
            default: begin
                if (up_at >= 0) begin
                    heading_now = edd_pkg::HEAD_UP;
                    target_now  = edd_pkg::t_floor'(up_at);
                end else if (dn_at >= 0) begin
                    heading_now = edd_pkg::HEAD_DOWN;
                    target_now  = edd_pkg::t_floor'(dn_at);
                end else begin
                    heading_now = edd_pkg::HEAD_IDLE;
                    target_now  = r.car_floor;
                end
            end
        endcase
        m.dest_floor = target_now;
        m.heading    = heading_now;
        return m;
    endfunction

    // A few scattered calls, as real traffic mostly looks.
    function automatic edd_pkg::t_mask sparse_calls();
        edd_pkg::t_mask m;
        m = '0;
        repeat ($urandom_range(3)) m[$urandom_range(edd_pkg::MASK_BITS - 1)] = 1'b1;
        return m;
    endfunction

    function automatic edd_pkg::t_mask random_calls();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return sparse_calls();
        if (pick < 85) return edd_pkg::t_mask'($urandom);
        if (pick < 93) return '0;
        return '1;
    endfunction

    // Let the cabin mostly walk floor by floor, with an occasional jump.
    function automatic edd_pkg::t_req random_call();
        edd_pkg::t_req r;
        if ($urandom_range(99) < 70) begin
            if ($urandom_range(1) == 1) walk_floor = (walk_floor < 15) ? walk_floor + 1 : 14;
            else walk_floor = (walk_floor > 0) ? walk_floor - 1 : 1;
        end else begin
            walk_floor = $urandom_range(15);
        end
        r.hall_up_mask   = random_calls();
        r.hall_down_mask = random_calls();
        r.cabin_mask     = random_calls();
        r.car_floor      = edd_pkg::t_floor'(walk_floor);
        r.cabin_full     = ($urandom_range(99) < 30);
        return r;
    endfunction

    task automatic add_call(input edd_pkg::t_mask hu, input edd_pkg::t_mask hd,
                            input edd_pkg::t_mask cab, input int cur, input logic full);
        edd_pkg::t_req r;
        r.hall_up_mask   = hu;
        r.hall_down_mask = hd;
        r.cabin_mask     = cab;
        r.car_floor      = edd_pkg::t_floor'(cur);
        r.cabin_full     = full;
        pending_calls = {pending_calls, r};
    endtask

    // Driver: change inputs at the falling edge. Offer a new transaction only
    // once the previous one was taken or the channel was empty.
    always @(negedge i_clk) begin
        edd_pkg::t_req nxt;
        logic src_hold;
        logic sink_hold;
        src_hold  = ((pace == PACE_SRC_GAPS) && ($urandom_range(99) < 67)) ||
                    ((pace == PACE_BOTH_GAPS) && ($urandom_range(99) < 38));
        sink_hold = ((pace == PACE_SINK_STALLS) && ($urandom_range(99) < 67)) ||
                    ((pace == PACE_BOTH_GAPS) && ($urandom_range(99) < 38));
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (!req_ch.valid || req_taken) begin
                if (pending_calls.size() != 0 && !src_hold) begin
                    nxt = pending_calls.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.hall_up_mask   <= nxt.hall_up_mask;
                    req_ch.hall_down_mask <= nxt.hall_down_mask;
                    req_ch.cabin_mask     <= nxt.cabin_mask;
                    req_ch.car_floor      <= nxt.car_floor;
                    req_ch.cabin_full     <= nxt.cabin_full;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= !sink_hold;
        end
    end

    // Monitor: at the rising edge, predict each accepted request, then check
    // each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        edd_pkg::t_req got_req;
        t_move         exp_move;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken) begin
                got_req.hall_up_mask   = req_ch.hall_up_mask;
                got_req.hall_down_mask = req_ch.hall_down_mask;
                got_req.cabin_mask     = req_ch.cabin_mask;
                got_req.car_floor      = req_ch.car_floor;
                got_req.cabin_full     = req_ch.cabin_full;
                expected_moves = {expected_moves, dispatch_step(got_req)};
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_moves.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result floor=%0d heading=%0d",
                             $time, rsp_ch.next_floor, rsp_ch.heading);
                end else begin
                    exp_move = expected_moves.pop_front();
                    if (rsp_ch.next_floor !== exp_move.dest_floor) begin
                        mismatches++;
                        $display("%0t: next_floor expected %0d actual %0d",
                                 $time, exp_move.dest_floor, rsp_ch.next_floor);
                    end
                    if (rsp_ch.heading !== exp_move.heading) begin
                        mismatches++;
                        $display("%0t: heading expected %0d actual %0d",
                                 $time, exp_move.heading, rsp_ch.heading);
                    end
                end
            end
        end
    end

    initial begin
        heading_now = edd_pkg::HEAD_IDLE;
        target_now  = '0;
        mismatches  = 0;
        walk_floor  = 0;
        req_taken   = 1'b0;
        pace        = PACE_STEADY;
        i_rst_n     = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.hall_up_mask   = '0;
        req_ch.hall_down_mask = '0;
        req_ch.cabin_mask     = '0;
        req_ch.car_floor      = '0;
        req_ch.cabin_full     = 1'b0;
        rsp_ch.ready          = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed walk through every heading transition and scan corner.
        add_call('0, '0, '0, 5, 1'b0);                      // idle, no calls
        add_call('0, '0, 16'h0200, 3, 1'b0);                // idle to up
        add_call(16'h1000, '0, '0, 9, 1'b0);                // keep going up
        add_call(16'h1000, '0, '0, 12, 1'b1);               // full skips own floor
        add_call('0, 16'h0004, '0, 12, 1'b0);               // idle to down
        add_call('0, '0, 16'h0001, 4, 1'b0);                // keep going down
        add_call(16'h0400, '0, '0, 0, 1'b0);                // down reverses up
        add_call('0, 16'h0008, '0, 10, 1'b0);               // up reverses down
        add_call('0, '0, '0, 3, 1'b0);                      // down turns idle
        add_call(16'h0080, '0, '0, 7, 1'b0);                // hall up at own floor
        add_call('0, 16'h0080, 16'h0080, 7, 1'b1);          // full, cabin call counts
        add_call('0, 16'h8000, '0, 4, 1'b0);                // down call above, going up
        add_call(16'h0001, '0, '0, 15, 1'b0);               // up call below, top floor
        add_call('1, '1, '1, 0, 1'b1);                      // every call, bottom floor
        add_call('1, '1, '1, 15, 1'b0);                     // every call, top floor
        add_call('1, '1, '0, 8, 1'b1);                      // full, hall calls only
        add_call('0, '0, 16'h8001, 15, 1'b1);               // cabin calls at both ends
        add_call('0, '0, '0, 15, 1'b0);                     // down turns idle
        add_call('0, '0, '0, 15, 1'b0);                     // idle at top floor
        add_call('0, '0, '0, 0, 1'b0);                      // idle at bottom floor

        // Random traffic, one pacing per phase; move on once the queue drains.
        for (int ph = 0; ph < 4; ph++) begin
            pace = t_pace'(ph);
            for (int n = 0; n < PHASE_CALLS; n++) pending_calls = {pending_calls, random_call()};
            while (pending_calls.size() != 0) @(posedge i_clk);
        end

        // Drain: wait out the last requests and results, then the pipeline.
        while (req_ch.valid || expected_moves.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
